// ----- rtl/quaternion_rigid_point_transform_top_assert.svh -----
// Assertion macros for the quaternion rigid point transform.
// Depends on nothing; included by the top level.
`ifndef QUATERNION_RIGID_POINT_TRANSFORM_TOP_ASSERT_SVH
`define QUATERNION_RIGID_POINT_TRANSFORM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define QRPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qrpt: assertion failed");
// Clocked check that also runs during reset.
`define QRPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qrpt: assertion failed");
`else
`define QRPT_ASSERT(label, clk, rst_n, prop)
`define QRPT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/qrpt_pkg.sv -----
// Shared types and constants of the quaternion rigid point transform.
// No dependencies; imported by every module of the block.
package qrpt_pkg;

    localparam int POINT_WIDTH    = 32;
    localparam int QUAT_WIDTH_DEF = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = POINT_WIDTH;
    // Width of one component of t = 2 * cross(q.xyz, p)
    localparam int T_WIDTH_DEF    = QUAT_WIDTH_DEF + POINT_WIDTH + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd6;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] point_x;
        logic signed [POINT_WIDTH-1:0] point_y;
        logic signed [POINT_WIDTH-1:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] moved_x;
        logic signed [POINT_WIDTH-1:0] moved_y;
        logic signed [POINT_WIDTH-1:0] moved_z;
        logic                          overflow;
    } t_point_out;

endpackage

// ----- rtl/qrpt_tmul.sv -----
// Two-stage signed multiplier for a quaternion component times a wide t term.
// Depends on qrpt_pkg for default widths.
module qrpt_tmul #(
    parameter int A_WIDTH = qrpt_pkg::QUAT_WIDTH_DEF,
    parameter int B_WIDTH = qrpt_pkg::T_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic signed [A_WIDTH-1:0]          i_a,
    input  logic signed [B_WIDTH-1:0]          i_b,
    output logic signed [A_WIDTH+B_WIDTH-1:0]  o_p
);
    import qrpt_pkg::*;

    localparam int LW = B_WIDTH / 2;
    localparam int HW = B_WIDTH - LW;
    localparam int PW = A_WIDTH + B_WIDTH;

    logic signed [A_WIDTH+LW:0]   r_lo;
    logic signed [A_WIDTH+HW-1:0] r_hi;
    logic signed [PW-1:0]         r_p;

    // Stage A: split b into an unsigned low half and a signed high half.
    always_ff @(posedge i_clk) begin
        r_lo <= i_a * $signed({1'b0, i_b[LW-1:0]});
        r_hi <= i_a * $signed(i_b[B_WIDTH-1:LW]);
    end

    // Stage B: recombine the partial products.
    always_ff @(posedge i_clk) begin
        r_p <= (PW'(r_hi) <<< LW) + PW'(r_lo);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/quaternion_rigid_point_transform_top.sv -----
// Quaternion rigid point transform: top level with the full datapath.
// Depends on qrpt_pkg, qrpt_tmul and the assertion macro header.
//
// Usage:
//  - Request channel: drive i_point and raise i_start; the request is taken at
//    a rising edge with i_start high and o_busy low. o_busy is high only while
//    reset is held, so one point can be taken on every cycle.
//  - Result channel: o_done is high for exactly one cycle with o_result; the
//    receiver cannot hold results off and must take every one.
//  - Throughput: one point per cycle, set by the six-register pipeline: cross
//    products, t, two stages of split 32x66 multiplies, partial sums, then
//    round and saturate into the output register.
//  - Configuration: write quat_x..quat_w (indexes 0..3, Q2.30) and
//    offset_x..offset_z (indexes 4..6, Q16.16) through i_cfg_we, i_cfg_idx,
//    i_cfg_data while no request is in flight. Other indexes are dropped.
//  - Reset (synchronous, active low): clear all valid bits, load the
//    identity transform (w = one, everything else zero).
//  - A coordinate that leaves the Q16.16 range saturates and sets overflow.
`include "quaternion_rigid_point_transform_top_assert.svh"
module quaternion_rigid_point_transform_top #(
    parameter int QUAT_WIDTH = qrpt_pkg::QUAT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  qrpt_pkg::t_point_in                i_point,
    output logic                               o_done,
    output qrpt_pkg::t_point_out               o_result,
    input  logic                               i_cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qrpt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import qrpt_pkg::*;

    localparam int PW    = POINT_WIDTH;
    localparam int QFRAC = QUAT_WIDTH - 2;
    localparam int SHIFT = 2 * QFRAC;
    localparam int PRW1  = QUAT_WIDTH + PW;     // q * p
    localparam int TW    = PRW1 + 2;            // t = 2 * (q*p - q*p)
    localparam int PRW2  = QUAT_WIDTH + TW;     // q * t
    localparam int SW    = PRW2 + 3;            // exact sum

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QFRAC;
    localparam logic signed [SW-1:0]         HALF     = SW'(1) << (SHIFT - 1);
    localparam logic [PW-1:0] SAT_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] SAT_MIN = {1'b1, {(PW-1){1'b0}}};

    // Cyclic neighbors of each axis for the cross products.
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    // Configuration: quaternion x, y, z, w and the offset.
    logic signed [QUAT_WIDTH-1:0] r_quat [4];
    logic signed [PW-1:0]         r_ofs  [3];

    logic w_accept;
    logic signed [PW-1:0] w_pin [3];

    // Pipeline registers
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r_done;
    logic signed [PW-1:0]   r1_p [3];
    logic signed [PW-1:0]   r2_p [3];
    logic signed [PW-1:0]   r3_p [3];
    logic signed [PW-1:0]   r4_p [3];
    logic signed [PRW1-1:0] r1_pa [3];
    logic signed [PRW1-1:0] r1_pb [3];
    logic signed [TW-1:0]   r2_t [3];
    logic signed [PRW2-1:0] w_wt [3];
    logic signed [PRW2-1:0] w_ca [3];
    logic signed [PRW2-1:0] w_cb [3];
    logic signed [PW:0]     w_psum [3];
    logic signed [SW-1:0]   r5_a [3];
    logic signed [SW-1:0]   r5_c [3];

    logic signed [SW-1:0]   w_sum [3];
    logic signed [SW-1:0]   w_rnd [3];
    logic [SW-PW:0]         w_hi  [3];
    logic [PW-1:0]          w_val [3];
    logic [2:0]             w_sat;
    t_point_out             n_result;
    t_point_out             r_result;

    assign o_busy   = !i_rst_n;
    assign w_accept = i_start && !o_busy;
    assign w_pin[0] = i_point.point_x;
    assign w_pin[1] = i_point.point_y;
    assign w_pin[2] = i_point.point_z;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= '0;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= QUAT_ONE;
            r_ofs[0]  <= '0;
            r_ofs[1]  <= '0;
            r_ofs[2]  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUAT_X:   r_quat[0] <= i_cfg_data[QUAT_WIDTH-1:0];
                CFG_QUAT_Y:   r_quat[1] <= i_cfg_data[QUAT_WIDTH-1:0];
                CFG_QUAT_Z:   r_quat[2] <= i_cfg_data[QUAT_WIDTH-1:0];
                CFG_QUAT_W:   r_quat[3] <= i_cfg_data[QUAT_WIDTH-1:0];
                CFG_OFFSET_X: r_ofs[0]  <= i_cfg_data[PW-1:0];
                CFG_OFFSET_Y: r_ofs[1]  <= i_cfg_data[PW-1:0];
                CFG_OFFSET_Z: r_ofs[2]  <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits advance one stage per cycle; nothing ever stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_vld <= w_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r_done <= r5_vld;
        end
    end

    // Stage 1: the six q*p products of cross(q.xyz, p).
    // Stage 2: t = 2 * cross(q.xyz, p), exact.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_p[i]  <= w_pin[i];
            r1_pa[i] <= r_quat[NXT[i]] * w_pin[PRV[i]];
            r1_pb[i] <= r_quat[PRV[i]] * w_pin[NXT[i]];
            r2_p[i]  <= r1_p[i];
            r2_t[i]  <= (TW'(r1_pa[i]) - TW'(r1_pb[i])) <<< 1;
            r3_p[i]  <= r2_p[i];
            r4_p[i]  <= r3_p[i];
        end
    end

    // Stages 3 and 4: w*t and the q*t products of cross(q.xyz, t).
    for (genvar g = 0; g < 3; g++) begin : g_axis
        localparam int J = NXT[g];
        localparam int K = PRV[g];

        qrpt_tmul #(
            .A_WIDTH (QUAT_WIDTH),
            .B_WIDTH (TW)
        ) u_wt (
            .i_clk (i_clk),
            .i_a   (r_quat[3]),
            .i_b   (r2_t[g]),
            .o_p   (w_wt[g])
        );

        qrpt_tmul #(
            .A_WIDTH (QUAT_WIDTH),
            .B_WIDTH (TW)
        ) u_ca (
            .i_clk (i_clk),
            .i_a   (r_quat[J]),
            .i_b   (r2_t[K]),
            .o_p   (w_ca[g])
        );

        qrpt_tmul #(
            .A_WIDTH (QUAT_WIDTH),
            .B_WIDTH (TW)
        ) u_cb (
            .i_clk (i_clk),
            .i_a   (r_quat[K]),
            .i_b   (r2_t[J]),
            .o_p   (w_cb[g])
        );
    end

    // Stage 5: fold the rotation terms; point plus offset is aligned to the
    // product scale with the rounding half already in its low bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_psum[i] = (PW+1)'(r4_p[i]) + (PW+1)'(r_ofs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_a[i] <= (SW'(w_psum[i]) <<< SHIFT) + HALF;
            r5_c[i] <= SW'(w_wt[i]) + SW'(w_ca[i]) - SW'(w_cb[i]);
        end
    end

    // Stage 6: final sum, drop the fraction, saturate to the point width.
    always_comb begin
        n_result = '0;
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = r5_a[i] + r5_c[i];
            w_rnd[i] = w_sum[i] >>> SHIFT;
            w_hi[i]  = w_rnd[i][SW-1:PW-1];
            w_sat[i] = !((&w_hi[i]) || !(|w_hi[i]));
            if (!w_sat[i]) begin
                w_val[i] = w_rnd[i][PW-1:0];
            end else if (w_rnd[i][SW-1]) begin
                w_val[i] = SAT_MIN;
            end else begin
                w_val[i] = SAT_MAX;
            end
        end
        n_result.moved_x  = w_val[0];
        n_result.moved_y  = w_val[1];
        n_result.moved_z  = w_val[2];
        n_result.overflow = |w_sat;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every request yields its result, and no result comes without a request.
    `QRPT_ASSERT(a_req_to_done, i_clk, i_rst_n, i_start && !o_busy |-> ##6 o_done)
    `QRPT_ASSERT(a_done_has_req, i_clk, i_rst_n, o_done |-> $past(i_start && !o_busy, 6))
    // Overflow is reported only with a coordinate pinned at a range limit.
    `QRPT_ASSERT(a_ovf_sat, i_clk, i_rst_n, o_done && o_result.overflow |-> (o_result.moved_x == SAT_MAX) || (o_result.moved_x == SAT_MIN) || (o_result.moved_y == SAT_MAX) || (o_result.moved_y == SAT_MIN) || (o_result.moved_z == SAT_MAX) || (o_result.moved_z == SAT_MIN))
    // Nothing enters the pipe while reset is held.
    `QRPT_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !r1_vld)

endmodule

// ----- bench/qrpt_transform_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the quaternion rigid point transform: mirrors the config
// registers, predicts every moved point and checks the results in order.
// Depends on qrpt_pkg.
module qrpt_transform_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  qrpt_pkg::t_point_in             i_point,
    input  logic                            i_done,
    input  qrpt_pkg::t_point_out            i_result,
    input  logic                            i_cfg_we,
    input  logic [qrpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qrpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import qrpt_pkg::*;

    localparam int QUAT_FRAC  = QUAT_WIDTH_DEF - 2;
    localparam int ACC_SHIFT  = 2 * QUAT_FRAC;
    localparam int REG_COUNT  = 7;
    localparam int REPORT_MAX = 10;
    localparam logic signed [127:0] MOVED_MAX  = (128'sd1 <<< (POINT_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] MOVED_MIN  = -(128'sd1 <<< (POINT_WIDTH - 1));
    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (ACC_SHIFT - 1);

    logic signed [CFG_DATA_W-1:0] transform_regs [REG_COUNT];
    t_point_out                   moved_point_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Round to nearest (ties up) back to Q16.16 and clamp; top bit is the clamp flag.
    function automatic logic [POINT_WIDTH:0] round_clamp(input logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + ROUND_HALF) >>> ACC_SHIFT;
        if (r > MOVED_MAX)
            return {1'b1, MOVED_MAX[POINT_WIDTH-1:0]};
        if (r < MOVED_MIN)
            return {1'b1, MOVED_MIN[POINT_WIDTH-1:0]};
        return {1'b0, r[POINT_WIDTH-1:0]};
    endfunction

    function automatic t_point_out predict_moved_point(input t_point_in p);
        logic signed [127:0] px, py, pz, qx, qy, qz, qw, ox, oy, oz;
        logic signed [127:0] tx, ty, tz, sx, sy, sz;
        logic [POINT_WIDTH:0] cx, cy, cz;
        t_point_out m;
        px = $signed(p.point_x);
        py = $signed(p.point_y);
        pz = $signed(p.point_z);
        qx = $signed(transform_regs[CFG_QUAT_X]);
        qy = $signed(transform_regs[CFG_QUAT_Y]);
        qz = $signed(transform_regs[CFG_QUAT_Z]);
        qw = $signed(transform_regs[CFG_QUAT_W]);
        ox = $signed(transform_regs[CFG_OFFSET_X]);
        oy = $signed(transform_regs[CFG_OFFSET_Y]);
        oz = $signed(transform_regs[CFG_OFFSET_Z]);
        // t = 2 * cross(q.xyz, p), exact
        tx = (qy * pz - qz * py) <<< 1;
        ty = (qz * px - qx * pz) <<< 1;
        tz = (qx * py - qy * px) <<< 1;
        sx = (px <<< ACC_SHIFT) + qw * tx + (qy * tz - qz * ty) + (ox <<< ACC_SHIFT);
        sy = (py <<< ACC_SHIFT) + qw * ty + (qz * tx - qx * tz) + (oy <<< ACC_SHIFT);
        sz = (pz <<< ACC_SHIFT) + qw * tz + (qx * ty - qy * tx) + (oz <<< ACC_SHIFT);
        cx = round_clamp(sx);
        cy = round_clamp(sy);
        cz = round_clamp(sz);
        m.moved_x  = cx[POINT_WIDTH-1:0];
        m.moved_y  = cy[POINT_WIDTH-1:0];
        m.moved_z  = cz[POINT_WIDTH-1:0];
        m.overflow = cx[POINT_WIDTH] | cy[POINT_WIDTH] | cz[POINT_WIDTH];
        return m;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_point_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++)
                transform_regs[i] = '0;
            transform_regs[CFG_QUAT_W] = 1 << QUAT_FRAC;
            moved_point_queue.delete();
        end else begin
            // unknown indexes are dropped by the block
            if (i_cfg_we && i_cfg_idx < REG_COUNT)
                transform_regs[i_cfg_idx] = i_cfg_data;
            if (i_done) begin
                if (moved_point_queue.size() == 0) begin
                    if (o_fail_count < REPORT_MAX)
                        $display("%0t: result with no request pending: x=%h y=%h z=%h ovf=%b",
                                 $realtime, i_result.moved_x, i_result.moved_y,
                                 i_result.moved_z, i_result.overflow);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = moved_point_queue.pop_front();
                    if (i_result.moved_x !== want.moved_x || i_result.moved_y !== want.moved_y ||
                        i_result.moved_z !== want.moved_z ||
                        i_result.overflow !== want.overflow) begin
                        if (o_fail_count < REPORT_MAX)
                            $display("%0t: mismatch: expected x=%h y=%h z=%h ovf=%b, got x=%h y=%h z=%h ovf=%b",
                                     $realtime, want.moved_x, want.moved_y, want.moved_z,
                                     want.overflow, i_result.moved_x, i_result.moved_y,
                                     i_result.moved_z, i_result.overflow);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                moved_point_queue.push_back(predict_moved_point(i_point));
        end
        o_pending = moved_point_queue.size();
    end

endmodule

// ----- bench/quaternion_rigid_point_transform_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the quaternion rigid point transform: drives points and
// config writes, gives the verdict. Depends on qrpt_pkg, the block and
// qrpt_transform_checker.
module quaternion_rigid_point_transform_top_tb;
    import qrpt_pkg::*;

    // Accept-to-result delay of the block; pad it a little for settling.
    localparam int LATENCY      = 6;
    localparam int SETTLE       = LATENCY + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_POINTS = 130;
    localparam int BURST_SPAN   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE     = 32'sh4000_0000;
    localparam logic signed [31:0] Q_HALF_RT = 32'sd759250125;   // cos(45 deg) in Q2.30
    localparam logic signed [31:0] Q_TIE     = 32'sh1000_0000;   // 1/4, exposes half-LSB ties
    localparam logic signed [31:0] UNIT      = 32'sh0001_0000;   // 1.0 in Q16.16

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    t_point_in  point;
    logic       done;
    t_point_out result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    bit burst;

    quaternion_rigid_point_transform_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_point    (point),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    qrpt_transform_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_point      (point),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: abort a hung run.
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_point_in make_point(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z);
        t_point_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // One of the corner values of a Q format field.
    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return Q_ONE;
        endcase
    endfunction

    // Mostly full-range coordinates, some small ones, some corners.
    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom;
        if (pick < 9)
            return $signed($urandom) >>> 11;
        return pick_extreme();
    endfunction

    // Present one request and hold it until the block takes it, then idle
    // for a random gap unless a burst is running. Keep start high across
    // back-to-back requests so it never toggles within one step.
    task automatic drive_point(input t_point_in p);
        int gap;
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            point <= {$urandom, $urandom, $urandom};   // junk while idle
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every expected result, then let the pipe settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Load the whole transform; call only while the block is idle.
    task automatic set_transform(input logic [31:0] qx, input logic [31:0] qy,
                                 input logic [31:0] qz, input logic [31:0] qw,
                                 input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] oz);
        write_reg(CFG_QUAT_X, qx);
        write_reg(CFG_QUAT_Y, qy);
        write_reg(CFG_QUAT_Z, qz);
        write_reg(CFG_QUAT_W, qw);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        cfg_we <= 1'b0;
    endtask

    // Pick a random transform of the given flavor and load it.
    task automatic load_random_transform(input int kind);
        logic [31:0] q [4];
        logic [31:0] o [3];
        for (int i = 0; i < 4; i++) begin
            case (kind)
                0:       q[i] = $signed($urandom) >>> 1;   // roughly unit-sized
                1:       q[i] = $urandom;
                2:       q[i] = pick_extreme();
                default: q[i] = (i == 3) ? Q_ONE : 32'd0;  // pure translation
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            case (kind)
                0:       o[i] = $signed($urandom) >>> 8;
                2:       o[i] = pick_extreme();
                default: o[i] = $urandom;
            endcase
        end
        set_transform(q[0], q[1], q[2], q[3], o[0], o[1], o[2]);
    endtask

    initial begin
        start    <= 1'b0;
        point    <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_QUAT_X;
        cfg_data <= '0;
        rst_n    <= 1'b0;
        burst    = 1'b0;

        // Hold reset, then release it for good.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset transform is identity: corners pass straight through.
        drive_point(make_point(32'd0, 32'd0, 32'd0));
        drive_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
        drive_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
        drive_point(make_point(32'd1, -32'sd1, 32'h1234_5678));
        drain();

        // A write to an unknown index must leave the transform alone.
        write_reg(CFG_UNUSED, 32'hdead_beef);
        cfg_we <= 1'b0;
        drive_point(make_point(32'd1, 32'd2, 32'd3));
        drain();

        // Offsets at the rails: saturate up on x, down on y.
        set_transform(32'd0, 32'd0, 32'd0, Q_ONE, COORD_MAX, COORD_MIN, 32'd0);
        drive_point(make_point(COORD_MAX, COORD_MIN, 32'd0));
        drive_point(make_point(32'd1, -32'sd1, 32'd0));
        drive_point(make_point(COORD_MIN, COORD_MAX, 32'd5));
        drain();

        // Non-unit quaternion with exact half-LSB ties on y and z.
        set_transform(Q_TIE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        drive_point(make_point(32'd0, 32'd4, -32'sd4));
        drive_point(make_point(32'd0, -32'sd4, 32'd4));
        drive_point(make_point(32'd7, 32'd1, -32'sd1));
        drive_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
        drain();

        // Quaternion at the negative rail, offsets at the positive one.
        set_transform(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, COORD_MAX);
        drive_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
        drive_point(make_point(32'd1, 32'd1, 32'd1));
        drive_point(make_point(COORD_MIN, 32'd0, COORD_MAX));
        drain();

        // And the other way round.
        set_transform(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      COORD_MIN, COORD_MIN, COORD_MIN);
        drive_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
        drive_point(make_point(32'd0, 32'd0, 32'd0));
        drive_point(make_point(COORD_MIN, 32'd0, COORD_MAX));
        drain();

        // Quarter turn about z: unit x goes to unit y.
        set_transform(32'd0, 32'd0, Q_HALF_RT, Q_HALF_RT, 32'd0, 32'd0, 32'd0);
        drive_point(make_point(UNIT, 32'd0, 32'd0));
        drive_point(make_point(32'd0, UNIT, 32'd0));
        drive_point(make_point(32'd123456, -32'sd654321, 32'd99));
        drain();

        // Random phases: new transform each phase, random points with gaps
        // and bursts, and one full pause in the middle of every phase.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            load_random_transform(ph % 4);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (n % BURST_SPAN == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (n == PHASE_POINTS / 2)
                    drain();
                drive_point(make_point(rand_coord(), rand_coord(), rand_coord()));
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
